>>> sv/oaat_pkg.sv
// ----------------------------------------------------------------------------
// oaat_pkg
// Shared widths, shift amounts, mix functions and stage type for the
// one-at-a-time string hash.
// ----------------------------------------------------------------------------
package oaat_pkg;

   localparam int CH_W   = 8;
   localparam int HASH_W = 64;

   localparam int MIX_SHL   = 10;
   localparam int MIX_SHR   = 6;
   localparam int FIN_SHL_A = 3;
   localparam int FIN_SHR_B = 11;
   localparam int FIN_SHL_C = 15;

   typedef logic [CH_W-1:0]   ch_type;
   typedef logic [HASH_W-1:0] hash_type;

   typedef struct packed {
      logic     valid;
      hash_type hash;
   } hash_stage_type;

   function automatic hash_type mix_byte(input hash_type h, input ch_type b);
      hash_type t;
      t = h + {{(HASH_W-CH_W){1'b0}}, b};
      t = t + (t << MIX_SHL);
      t = t ^ (t >> MIX_SHR);
      return t;
   endfunction

   // first two steps of the final mix
   function automatic hash_type final_mix_a(input hash_type h);
      hash_type t;
      t = h + (h << FIN_SHL_A);
      t = t ^ (t >> FIN_SHR_B);
      return t;
   endfunction

   function automatic hash_type final_mix_b(input hash_type h);
      return h + (h << FIN_SHL_C);
   endfunction

endpackage

>>> sv/one_at_a_time_string_hash.sv
// An accepted string end passes the input, mix, mid and response registers.
// Throughput: one request per cycle; stages hold only when the response is
// stalled, and empty stages ahead are filled while it waits.
// The running hash loop (byte add, shift-add, xor) closes on its own register.
// Reset clears the running hash and all valid flags; no response is pending.
// ----------------------------------------------------------------------------
// one_at_a_time_string_hash
// 64-bit one-at-a-time hash over a byte stream, one response per string.
// ----------------------------------------------------------------------------
module one_at_a_time_string_hash (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  oaat_pkg::ch_type   req_ch,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output oaat_pkg::hash_type rsp_hash
);
   import oaat_pkg::*;

   logic           in_valid_ff, in_valid_in;
   ch_type         in_ch_ff, in_ch_in;
   logic           in_last_ff, in_last_in;
   hash_stage_type mix_stage;
   logic           fin_take;
   logic           mix_en, in_en;

   always_comb begin
      mix_en = !mix_stage.valid || fin_take;
      in_en  = !in_valid_ff || mix_en;

      in_valid_in = in_en ? req_valid : in_valid_ff;
      in_ch_in    = in_en ? req_ch    : in_ch_ff;
      in_last_in  = in_en ? req_last  : in_last_ff;
   end

   assign req_stall = !in_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ch_ff   <= in_ch_in;
      in_last_ff <= in_last_in;
   end

   oaat_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ch     (in_ch_ff),
      .in_last   (in_last_ff),
      .advance   (mix_en),
      .out_stage (mix_stage)
   );

   oaat_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (mix_stage),
      .take      (fin_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_hash  (rsp_hash)
   );

endmodule

>>> sv/oaat_mix.sv
// ----------------------------------------------------------------------------
// oaat_mix
// Running hash: mixes each nonzero character in, and on the end of a
// string hands the hash on to the final mix and clears itself.
// ----------------------------------------------------------------------------
module oaat_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  oaat_pkg::ch_type        in_ch,
   input  logic                    in_last,
   input  logic                    advance,
   output oaat_pkg::hash_stage_type out_stage
);
   import oaat_pkg::*;

   hash_type running_hash_ff, running_hash_in;
   logic     valid_ff, valid_in;
   hash_type hash_ff, hash_in;
   hash_type mixed;
   logic     str_end;

   always_comb begin
      mixed   = (in_ch != '0) ? mix_byte(running_hash_ff, in_ch) : running_hash_ff;
      str_end = (in_ch == '0) || in_last;

      running_hash_in = running_hash_ff;
      valid_in        = valid_ff;
      hash_in         = hash_ff;
      if (advance) begin
         valid_in = in_valid && str_end;
         hash_in  = mixed;
         if (in_valid) begin
            running_hash_in = str_end ? '0 : mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
         valid_ff        <= 1'b0;
      end else begin
         running_hash_ff <= running_hash_in;
         valid_ff        <= valid_in;
      end
      hash_ff <= hash_in;
   end

   assign out_stage.valid = valid_ff;
   assign out_stage.hash  = hash_ff;

endmodule

>>> sv/oaat_final.sv
// ----------------------------------------------------------------------------
// oaat_final
// Final mix over two register stages, ending in the response register.
// ----------------------------------------------------------------------------
module oaat_final (
   input  logic                     clock,
   input  logic                     reset,
   input  oaat_pkg::hash_stage_type in_stage,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output oaat_pkg::hash_type       rsp_hash
);
   import oaat_pkg::*;

   logic     mid_valid_ff, mid_valid_in;
   hash_type mid_hash_ff, mid_hash_in;
   logic     out_valid_ff, out_valid_in;
   hash_type out_hash_ff, out_hash_in;
   logic     out_en, mid_en;

   always_comb begin
      out_en = !out_valid_ff || !rsp_stall;
      mid_en = !mid_valid_ff || out_en;

      mid_valid_in = mid_en ? in_stage.valid : mid_valid_ff;
      mid_hash_in  = mid_en ? final_mix_a(in_stage.hash) : mid_hash_ff;
      out_valid_in = out_en ? mid_valid_ff : out_valid_ff;
      out_hash_in  = out_en ? final_mix_b(mid_hash_ff) : out_hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
      mid_hash_ff <= mid_hash_in;
      out_hash_ff <= out_hash_in;
   end

   assign take      = mid_en;
   assign rsp_valid = out_valid_ff;
   assign rsp_hash  = out_hash_ff;

endmodule

>>> sv/oaat_checker.sv
// ----------------------------------------------------------------------------
// oaat_checker
// Port-level checks on the one-at-a-time string hash.
// ----------------------------------------------------------------------------
module oaat_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input oaat_pkg::ch_type   req_ch,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input oaat_pkg::hash_type rsp_hash
);
   import oaat_pkg::*;

   // nothing pending straight after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response or request stall present after reset");

   // requests back up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with no stalled response");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hash)))
      else $error("stalled response dropped or changed");

   // a request that ends a string, taken with no response pending and no response stall, reaches rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && ((req_ch == '0) || req_last) && !rsp_valid && !rsp_stall)
      ##1 (!rsp_stall) ##1 (!rsp_stall) ##1 (!rsp_stall) |=> rsp_valid)
      else $error("response missing after end of string");

endmodule

bind one_at_a_time_string_hash oaat_checker u_oaat_checker (.*);

>>> bench/tb_one_at_a_time_string_hash.sv
// ----------------------------------------------------------------------------
// tb_one_at_a_time_string_hash
// Streams strings into the 64-bit one-at-a-time hash block, one byte per
// request. Each accepted request is folded into a local copy of the running
// hash. The finished hashes are queued and checked in order against
// rsp_hash. The sender works in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module tb_one_at_a_time_string_hash;
   timeunit 1ns;
   timeprecision 1ps;

   import oaat_pkg::*;

   localparam int unsigned STRING_TARGET = 1250;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_EVERY   = 300;

   typedef enum int unsigned {
      END_ZERO,
      END_ZERO_LAST,
      END_LAST_FLAG
   } string_end_type;

   typedef struct {
      ch_type ch;
      logic   last;
      bit     hold_until_drained;
   } char_request_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   ch_type   req_ch = '0;
   logic     req_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   hash_type rsp_hash;

   char_request_type pending_chars[$];
   hash_type         expected_hashes[$];
   hash_type         string_hash = '0;

   int unsigned requests_queued = 0;
   bit          next_hold = 1'b0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned free_left = 0;

   one_at_a_time_string_hash u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_hash  (rsp_hash)
   );

   always #2 clock = ~clock;

   // Fold one accepted byte into the running hash; return 1 when the string
   // ends, with the finished hash in digest.
   function automatic bit absorb_char(input ch_type c, input logic lst,
                                      output hash_type digest);
      hash_type h;
      h = string_hash;
      digest = '0;
      if (c != '0) begin
         h = h + {{(HASH_W-CH_W){1'b0}}, c};
         h = h + (h << MIX_SHL);
         h = h ^ (h >> MIX_SHR);
         string_hash = h;
         if (!lst) begin
            return 1'b0;
         end
      end
      h = h + (h << FIN_SHL_A);
      h = h ^ (h >> FIN_SHR_B);
      h = h + (h << FIN_SHL_C);
      digest = h;
      string_hash = '0;
      return 1'b1;
   endfunction

   task automatic queue_char(input ch_type c, input logic lst);
      char_request_type r;
      r.ch = c;
      r.last = lst;
      r.hold_until_drained = next_hold;
      next_hold = 1'b0;
      pending_chars.push_back(r);
      requests_queued++;
   endtask

   task automatic queue_random_string(input int unsigned len);
      string_end_type kind;
      kind = string_end_type'($urandom_range(0, 2));
      if (len == 0 && kind == END_LAST_FLAG) begin
         kind = END_ZERO;
      end
      for (int unsigned i = 0; i < len; i++) begin
         queue_char(ch_type'($urandom_range(1, 255)),
                    (i == len - 1) && (kind == END_LAST_FLAG));
      end
      if (kind != END_LAST_FLAG) begin
         queue_char('0, kind == END_ZERO_LAST);
      end
   endtask

   initial begin
      int unsigned next_drain;
      int unsigned pick;
      int unsigned len;

      // empty strings, with and without last
      queue_char(8'h00, 1'b0);
      queue_char(8'h00, 1'b1);
      // single characters ending on last
      queue_char(8'h61, 1'b1);
      queue_char(8'hFF, 1'b1);
      queue_char(8'h01, 1'b1);
      // ended by a zero byte
      queue_char(8'h61, 1'b0);
      queue_char(8'h62, 1'b0);
      queue_char(8'h63, 1'b0);
      queue_char(8'h00, 1'b0);
      // last on a nonzero byte
      queue_char(8'hFF, 1'b0);
      queue_char(8'h80, 1'b0);
      queue_char(8'h7F, 1'b1);
      // zero byte carrying last after characters
      queue_char(8'h78, 1'b0);
      queue_char(8'h00, 1'b1);
      queue_char(8'hFF, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'h00, 1'b0);

      next_hold = 1'b1;
      next_drain = requests_queued + DRAIN_EVERY;
      while (requests_queued < STRING_TARGET) begin
         if (requests_queued >= next_drain) begin
            next_hold = 1'b1;
            next_drain = requests_queued + DRAIN_EVERY;
         end
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            // noise: any byte, any last
            repeat ($urandom_range(1, 4)) begin
               queue_char(ch_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end else begin
            if (pick == 2) len = 0;
            else if (pick < 16) len = $urandom_range(1, 12);
            else if (pick < 19) len = $urandom_range(13, 40);
            else len = $urandom_range(64, 200);
            queue_random_string(len);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_valid) @(posedge clock);
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_one_at_a_time_string_hash: done, clean");
      end else begin
         $display("tb_one_at_a_time_string_hash: done, errors");
      end
      $finish;
   end

   always @(posedge clock) begin : driver
      hash_type digest;
      bit       present;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (absorb_char(req_ch, req_last, digest)) begin
               expected_hashes.push_back(digest);
            end
         end
         // a stalled request holds; otherwise advance
         if (!req_valid || !req_stall) begin
            present = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].hold_until_drained &&
                           expected_hashes.size() != 0)) begin
               req_ch <= pending_chars[0].ch;
               req_last <= pending_chars[0].last;
               void'(pending_chars.pop_front());
               present = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= present;
         end
      end
   end

   always @(posedge clock) begin : monitor
      hash_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $error("rsp_hash: response with no string pending, actual %h", rsp_hash);
               error_count++;
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash !== want) begin
                  $error("rsp_hash mismatch: expected %h, actual %h", want, rsp_hash);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               free_left = $urandom_range(20, 80);
            end else begin
               stall_left = $urandom_range(1, 8);
               free_left = $urandom_range(0, 4);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_one_at_a_time_string_hash: done, errors");
         $finish;
      end
   end

endmodule

>>> sim.f
sv/oaat_pkg.sv
sv/oaat_mix.sv
sv/oaat_final.sv
sv/one_at_a_time_string_hash.sv
sv/oaat_checker.sv
bench/tb_one_at_a_time_string_hash.sv
